// ----- hw/rtl/text_console_engine_unit_assert.svh -----
// Assertion macros shared by the console engine RTL.
// Needs i_clk and i_rst_n in the scope of the module that uses them.
`ifndef TEXT_CONSOLE_ENGINE_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_ENGINE_UNIT_ASSERT_SVH

// Clocked property, off while reset is held.
`define TCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be seen.
`define TCE_NEVER(label, cond, msg) \
    `TCE_ASSERT(label, !(cond), msg)

`endif

// ----- hw/rtl/tce_pkg.sv -----
// Shared constants, op codes and controller/datapath interface types
// for the text console engine. No dependencies.
package tce_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    localparam logic [2:0] OP_PUT        = 3'd0;
    localparam logic [2:0] OP_WRITE_AT   = 3'd1;
    localparam logic [2:0] OP_SET_CURSOR = 3'd2;
    localparam logic [2:0] OP_CLEAR      = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [7:0] ATTR_RESET = 8'h07;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic sweep;      // screen sweep step (init, clear or scroll)
        logic read_load;  // read data ready, load result
    } t_tce_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_sweep;
        logic need_read;
        logic sweep_done;
        logic out_free;
    } t_tce_status;

endpackage

// ----- hw/rtl/text_console_engine_unit.sv -----
// Top level of the text console engine: 80x25 cell screen with cursor.
// Depends on tce_pkg, tce_ctrl, tce_datapath and tce_ram.

// Text-mode console engine. Each input beat (op, ch, row, col, fg, bg,
// burst_end) yields exactly one result beat. Put char, write at, set cursor,
// clear and out-of-range reads load the result register at accept, which
// waits for it to be free; an in-range read loads it in the read state, from
// the registered read of the screen RAM. A scrolling put char and a clear
// each walk the whole screen store through its single write port with the
// input stalled. After reset the same walk zeroes the store before the
// first beat is taken. The attribute register is written through the
// config channel, always ready, and must only be written while idle.
module text_console_engine_unit
    import tce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_op,
    input  logic [7:0]        i_ch,
    input  logic [7:0]        i_row,
    input  logic [7:0]        i_col,
    input  logic [3:0]        i_fg,
    input  logic [3:0]        i_bg,
    input  logic              i_burst_end,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic [COL_W-1:0]  o_cursor_col,
    output logic              o_cursor_strobe,
    output logic              o_cell_valid,
    output logic              o_cell_is_write,
    output logic [IDX_W-1:0]  o_cell_index,
    output logic [7:0]        o_cell_char,
    output logic [7:0]        o_cell_attr,
    output logic              o_scrolled
);

    t_tce_cmd    cmd;
    t_tce_status status;

    assign o_cfg_ready = 1'b1;

    tce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tce_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_ch            (i_ch),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_fg            (i_fg),
        .i_bg            (i_bg),
        .i_burst_end     (i_burst_end),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_strobe (o_cursor_strobe),
        .o_cell_valid    (o_cell_valid),
        .o_cell_is_write (o_cell_is_write),
        .o_cell_index    (o_cell_index),
        .o_cell_char     (o_cell_char),
        .o_cell_attr     (o_cell_attr),
        .o_scrolled      (o_scrolled)
    );

endmodule

// ----- hw/rtl/tce_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/tce_datapath.sv -----
// Console engine datapath: cursor, attribute register, screen RAM,
// sweep counter and result register. Uses tce_pkg and tce_ram.
`include "text_console_engine_unit_assert.svh"

module tce_datapath
    import tce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tce_cmd          i_cmd,
    output t_tce_status       o_status,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_data,
    input  logic [2:0]        i_op,
    input  logic [7:0]        i_ch,
    input  logic [7:0]        i_row,
    input  logic [7:0]        i_col,
    input  logic [3:0]        i_fg,
    input  logic [3:0]        i_bg,
    input  logic              i_burst_end,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic [COL_W-1:0]  o_cursor_col,
    output logic              o_cursor_strobe,
    output logic              o_cell_valid,
    output logic              o_cell_is_write,
    output logic [IDX_W-1:0]  o_cell_index,
    output logic [7:0]        o_cell_char,
    output logic [7:0]        o_cell_attr,
    output logic              o_scrolled
);

    typedef enum logic [1:0] {
        SW_INIT,
        SW_CLEAR,
        SW_COPY
    } t_sweep_mode;

    localparam logic [IDX_W-1:0] COPY_END  = IDX_W'(CELL_COUNT - COLUMNS);
    localparam logic [IDX_W-1:0] SWEEP_END = IDX_W'(CELL_COUNT);

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [7:0]       r_attr;
    logic [IDX_W-1:0] r_k;
    t_sweep_mode      r_mode;

    logic             r_out_valid;
    logic [ROW_W-1:0] r_o_row;
    logic [COL_W-1:0] r_o_col;
    logic             r_o_strobe;
    logic             r_o_cvalid;
    logic             r_o_cwrite;
    logic [IDX_W-1:0] r_o_index;
    logic [7:0]       r_o_char;
    logic [7:0]       r_o_attr;
    logic             r_o_scrolled;
    logic [IDX_W-1:0] r_rd_index;

    logic [IDX_W-1:0] cur_idx, in_idx, wr_idx;
    logic             in_ok, wr_en, strobe, wrap, need_sweep, need_read;
    logic [7:0]       wr_char, wr_attr;
    t_sweep_mode      mode_sel;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;
    logic             out_taken;

    assign cur_idx = IDX_W'(r_row) * IDX_W'(COLUMNS) + IDX_W'(r_col);
    assign in_ok   = (i_row < 8'(ROWS)) && (i_col < 8'(COLUMNS));
    assign in_idx  = IDX_W'(i_row[ROW_W-1:0]) * IDX_W'(COLUMNS) + IDX_W'(i_col[COL_W-1:0]);

    // item decode
    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        wr_en      = 1'b0;
        wr_idx     = cur_idx;
        wr_char    = i_ch;
        wr_attr    = r_attr;
        strobe     = 1'b0;
        wrap       = 1'b0;
        need_sweep = 1'b0;
        need_read  = 1'b0;
        mode_sel   = SW_COPY;
        unique case (i_op)
            OP_PUT: begin
                strobe = i_burst_end;
                priority if (i_ch == CH_NEWLINE) begin
                    n_col = '0;
                    if (r_row == ROW_LAST) begin
                        wrap = 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else if (i_ch == CH_RETURN) begin
                    n_col = '0;
                end else if (i_ch == CH_BACKSPACE) begin
                    if (r_row != '0 || r_col != '0) begin
                        wr_en   = 1'b1;
                        wr_idx  = cur_idx - 1'b1;
                        wr_char = CH_SPACE;
                        if (r_col == '0) begin
                            n_row = r_row - 1'b1;
                            n_col = COL_LAST;
                        end else begin
                            n_col = r_col - 1'b1;
                        end
                    end
                end else begin
                    wr_en = 1'b1;
                    if (r_col == COL_LAST) begin
                        n_col = '0;
                        if (r_row == ROW_LAST) begin
                            wrap = 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
                if (wrap) begin
                    n_row      = ROW_LAST;
                    n_col      = '0;
                    need_sweep = 1'b1;
                end
            end
            OP_WRITE_AT: begin
                if (in_ok) begin
                    wr_en   = 1'b1;
                    wr_idx  = in_idx;
                    wr_attr = {i_bg, i_fg};
                end
            end
            OP_SET_CURSOR: begin
                n_row  = (i_row >= 8'(ROWS)) ? ROW_LAST : i_row[ROW_W-1:0];
                n_col  = (i_col >= 8'(COLUMNS)) ? COL_LAST : i_col[COL_W-1:0];
                strobe = 1'b1;
            end
            OP_CLEAR: begin
                n_row      = '0;
                n_col      = '0;
                strobe     = 1'b1;
                need_sweep = 1'b1;
                mode_sel   = SW_CLEAR;
            end
            OP_READ: begin
                need_read = in_ok;
            end
            default: begin
            end
        endcase
    end

    // RAM port muxing: sweeps own both ports, items use them at accept.
    // Copy step k writes cell k-1 with the data read at step k-1 (cell k+79), or a blank past COPY_END.
    always_comb begin
        if (i_cmd.sweep) begin
            ram_we    = (r_k != '0);
            ram_waddr = r_k - 1'b1;
            ram_raddr = (r_k < COPY_END) ? r_k + IDX_W'(COLUMNS) : '0;
            unique case (r_mode)
                SW_INIT:  ram_wdata = '0;
                SW_CLEAR: ram_wdata = {r_attr, CH_SPACE};
                SW_COPY:  ram_wdata = (r_k <= COPY_END) ? ram_rdata : {r_attr, CH_SPACE};
                default:  ram_wdata = '0;
            endcase
        end else begin
            ram_we    = i_cmd.accept && wr_en;
            ram_waddr = wr_idx;
            ram_raddr = in_idx;
            ram_wdata = {wr_attr, wr_char};
        end
    end

    tce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_taken = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_attr      <= ATTR_RESET;
            r_k         <= '0;
            r_mode      <= SW_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_row <= n_row;
                r_col <= n_col;
                if (need_sweep) begin
                    r_k    <= '0;
                    r_mode <= mode_sel;
                end
            end else if (i_cmd.sweep && r_k != SWEEP_END) begin
                r_k <= r_k + 1'b1;
            end
            if ((i_cmd.accept && !need_read) || i_cmd.read_load) begin
                r_out_valid <= 1'b1;
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_index <= in_idx;
        end
        if (i_cmd.accept && !need_read) begin
            r_o_row      <= n_row;
            r_o_col      <= n_col;
            r_o_strobe   <= strobe;
            r_o_cvalid   <= wr_en;
            r_o_cwrite   <= wr_en;
            r_o_index    <= wr_en ? wr_idx : '0;
            r_o_char     <= wr_en ? wr_char : '0;
            r_o_attr     <= wr_en ? wr_attr : '0;
            r_o_scrolled <= wrap;
        end else if (i_cmd.read_load) begin
            r_o_row      <= r_row;
            r_o_col      <= r_col;
            r_o_strobe   <= 1'b0;
            r_o_cvalid   <= 1'b1;
            r_o_cwrite   <= 1'b0;
            r_o_index    <= r_rd_index;
            r_o_char     <= ram_rdata[7:0];
            r_o_attr     <= ram_rdata[15:8];
            r_o_scrolled <= 1'b0;
        end
    end

    assign o_status.need_sweep = need_sweep;
    assign o_status.need_read  = need_read;
    assign o_status.sweep_done = (r_k == SWEEP_END);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_cursor_row    = r_o_row;
    assign o_cursor_col    = r_o_col;
    assign o_cursor_strobe = r_o_strobe;
    assign o_cell_valid    = r_o_cvalid;
    assign o_cell_is_write = r_o_cwrite;
    assign o_cell_index    = r_o_index;
    assign o_cell_char     = r_o_char;
    assign o_cell_attr     = r_o_attr;
    assign o_scrolled      = r_o_scrolled;

    `TCE_ASSERT(a_cursor_range, (r_row <= ROW_LAST) && (r_col <= COL_LAST), "cursor left screen")
    `TCE_NEVER(a_sweep_bound, r_k > SWEEP_END, "sweep counter overran")
    `TCE_ASSERT(a_read_result, i_cmd.read_load |=> o_out_valid && o_cell_valid && !o_cell_is_write, "read beat not presented")

endmodule

// ----- hw/rtl/tce_ctrl.sv -----
// Console engine controller: sequences screen sweeps and cell reads,
// gates the input channel. Uses tce_pkg.
`include "text_console_engine_unit_assert.svh"

module tce_ctrl
    import tce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_tce_status i_status,
    output t_tce_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ
    } t_state;

    t_state r_state;
    logic   accept;

    assign o_in_stall = !((r_state == ST_IDLE) && i_status.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    assign o_cmd.accept    = accept;
    assign o_cmd.sweep     = (r_state == ST_SWEEP);
    assign o_cmd.read_load = (r_state == ST_READ);

    // reset starts in a sweep: screen store is zeroed before any item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            unique case (r_state)
                ST_SWEEP: begin
                    if (i_status.sweep_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept && i_status.need_sweep) begin
                        r_state <= ST_SWEEP;
                    end else if (accept && i_status.need_read) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `TCE_ASSERT(a_sweep_entry, accept && i_status.need_sweep |=> r_state == ST_SWEEP, "scroll or clear did not sweep")
    `TCE_ASSERT(a_read_entry, accept && i_status.need_read |=> r_state == ST_READ, "read not issued")
    `TCE_ASSERT(a_read_short, r_state == ST_READ |=> r_state == ST_IDLE && !$past(accept), "read state overstayed")

endmodule
